>>> design/pcap_pkg.sv
// Shared types and constants for the PCA projection core.
`timescale 1ns / 1ps

package pcap_pkg;

  localparam int MAX_DIM     = 16;
  localparam int SAMPLE_BITS = 16;
  localparam int IDX_W       = $clog2(MAX_DIM);
  localparam int POS_W       = $clog2(MAX_DIM + 1);
  localparam int COEF_W      = 16;
  localparam int PROD_W      = COEF_W + SAMPLE_BITS;
  localparam int ACC_W       = 36;
  localparam int EIGEN_W     = 32;
  localparam int FRAC_W      = 17;
  localparam int FRAC_SHIFT  = 16;
  localparam int TOTAL_W     = 36;
  localparam int HALF_W      = TOTAL_W / 2;
  localparam int PP_W        = HALF_W + FRAC_W;
  localparam int TARGET_W    = TOTAL_W + FRAC_W;
  localparam int CFG_IDX_W   = 2;

  localparam logic [FRAC_W-1:0] FRAC_ONE = FRAC_W'(1 << FRAC_SHIFT);

  localparam logic [1:0] OP_COEF   = 2'd0;
  localparam logic [1:0] OP_EIGEN  = 2'd1;
  localparam logic [1:0] OP_SAMPLE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_INPUT_DIM    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SELECT_VAR   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_KEEP_FRAC    = 2'd3;

  typedef struct packed {
    logic [1:0]                    opcode;
    logic [3:0]                    row_index;
    logic [3:0]                    column_index;
    logic signed [15:0]            coef_value;
    logic [31:0]                   eigen_value;
    logic signed [SAMPLE_BITS-1:0] sample_value;
  } in_item_t;

  typedef struct packed {
    logic [3:0]         component_index;
    logic signed [35:0] component_value;
    logic               last_component;
  } out_item_t;

  typedef struct packed {
    logic                   mac_en;
    logic [IDX_W-1:0]       pos;
    logic [SAMPLE_BITS-1:0] sample;
    logic [IDX_W-1:0]       coef_row;
    logic [COEF_W-1:0]      coef_value;
    logic                   shift;
    logic                   clear;
  } cell_ctl_t;

  typedef struct packed {
    logic [POS_W-1:0]  d;
    logic [POS_W-1:0]  output_count;
    logic              select_by_variance;
    logic [FRAC_W-1:0] keep_fraction;
  } sel_cfg_t;

  typedef struct packed {
    logic               we;
    logic [IDX_W-1:0]   idx;
    logic [EIGEN_W-1:0] value;
  } ev_wr_t;

  typedef struct packed {
    logic             done;
    logic [POS_W-1:0] count;
  } cnt_res_t;

endpackage

>>> design/pcap_mac_cell.sv
// Multiply-accumulate cell: one eigenvector column, one accumulator, shift link.
`timescale 1ns / 1ps

module pcap_mac_cell (
  input  logic                           clk,
  input  logic                           rst_n,
  input  pcap_pkg::cell_ctl_t            ctl,
  input  logic                           coef_we,
  input  logic [pcap_pkg::ACC_W-1:0]     acc_in,
  output logic [pcap_pkg::ACC_W-1:0]     acc_out
);

  logic [pcap_pkg::COEF_W-1:0]        coef_r [pcap_pkg::MAX_DIM];
  logic signed [pcap_pkg::COEF_W-1:0] coef_rd;
  logic signed [pcap_pkg::SAMPLE_BITS-1:0] sample_s;
  logic signed [pcap_pkg::PROD_W-1:0] product_r;
  logic                               prod_valid_r;
  logic [pcap_pkg::ACC_W-1:0]         acc_r;
  logic [pcap_pkg::ACC_W-1:0]         acc_nxt;
  logic [pcap_pkg::ACC_W-1:0]         product_ext;

  assign coef_rd  = $signed(coef_r[ctl.pos]);
  assign sample_s = $signed(ctl.sample);
  assign product_ext = {{(pcap_pkg::ACC_W - pcap_pkg::PROD_W){product_r[pcap_pkg::PROD_W-1]}},
                        product_r};

  always_comb begin
    acc_nxt = acc_r;
    if (ctl.clear) begin
      acc_nxt = '0;
    end else if (ctl.shift) begin
      acc_nxt = acc_in;
    end else if (prod_valid_r) begin
      acc_nxt = acc_r + product_ext;
    end
  end

  always_ff @(posedge clk) begin
    if (coef_we) begin
      coef_r[ctl.coef_row] <= ctl.coef_value;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.mac_en) begin
      product_r <= coef_rd * sample_s;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_valid_r <= 1'b0;
      acc_r        <= '0;
    end else begin
      prod_valid_r <= ctl.mac_en;
      acc_r        <= acc_nxt;
    end
  end

  assign acc_out = acc_r;

endmodule

>>> design/pcap_count_sel.sv
// Count selector: fixed, all d at zero share, or shortest eigenvalue prefix reaching the kept share.
`timescale 1ns / 1ps

module pcap_count_sel (
  input  logic                clk,
  input  logic                rst_n,
  input  pcap_pkg::sel_cfg_t  cfg,
  input  pcap_pkg::ev_wr_t    ev_wr,
  input  logic                start,
  output pcap_pkg::cnt_res_t  res
);

  typedef enum logic [2:0] {
    SEL_IDLE,
    SEL_SUM,
    SEL_MUL_LO,
    SEL_MUL_HI,
    SEL_ADD,
    SEL_SCAN,
    SEL_DONE
  } sel_state_t;

  sel_state_t state_r, state_nxt;

  logic [pcap_pkg::EIGEN_W-1:0]  ev_r [pcap_pkg::MAX_DIM];
  logic [pcap_pkg::EIGEN_W-1:0]  ev_rd;
  logic [pcap_pkg::POS_W-1:0]    d_r, d_nxt;
  logic [pcap_pkg::POS_W-1:0]    cnt_r, cnt_nxt;
  logic [pcap_pkg::POS_W-1:0]    count_r, count_nxt;
  logic [pcap_pkg::FRAC_W-1:0]   frac_r, frac_nxt;
  logic [pcap_pkg::TOTAL_W-1:0]  total_r, total_nxt;
  logic [pcap_pkg::TOTAL_W-1:0]  kept_r, kept_nxt;
  logic [pcap_pkg::TARGET_W-1:0] target_r, target_nxt;
  logic [pcap_pkg::PP_W-1:0]     prod_r, prod_nxt;
  logic [pcap_pkg::HALF_W-1:0]   mul_a;
  logic [pcap_pkg::FRAC_W-1:0]   frac_clamp;
  logic [pcap_pkg::POS_W-1:0]    fixed_n;
  logic [pcap_pkg::POS_W-1:0]    cnt_inc;
  logic [pcap_pkg::TARGET_W-1:0] kept_scaled;
  logic                          scan_go;

  assign ev_rd   = ev_r[cnt_r[pcap_pkg::IDX_W-1:0]];
  assign cnt_inc = cnt_r + 1'b1;

  assign frac_clamp = (cfg.keep_fraction > pcap_pkg::FRAC_ONE) ? pcap_pkg::FRAC_ONE
                                                               : cfg.keep_fraction;

  assign fixed_n = (cfg.output_count == '0)  ? pcap_pkg::POS_W'(1) :
                   (cfg.output_count > cfg.d) ? cfg.d : cfg.output_count;

  assign mul_a = (state_r == SEL_MUL_LO) ? total_r[pcap_pkg::HALF_W-1:0]
                                         : total_r[pcap_pkg::TOTAL_W-1:pcap_pkg::HALF_W];

  assign kept_scaled = pcap_pkg::TARGET_W'({kept_r, {pcap_pkg::FRAC_SHIFT{1'b0}}});
  assign scan_go     = (cnt_r < d_r) && (kept_scaled < target_r);

  always_comb begin
    state_nxt  = state_r;
    d_nxt      = d_r;
    cnt_nxt    = cnt_r;
    count_nxt  = count_r;
    frac_nxt   = frac_r;
    total_nxt  = total_r;
    kept_nxt   = kept_r;
    target_nxt = target_r;
    prod_nxt   = prod_r;
    case (state_r)
      SEL_IDLE, SEL_DONE: begin
        if (start) begin
          d_nxt     = cfg.d;
          frac_nxt  = frac_clamp;
          total_nxt = '0;
          cnt_nxt   = '0;
          if (!cfg.select_by_variance) begin
            count_nxt = fixed_n;
            state_nxt = SEL_DONE;
          end else if (cfg.keep_fraction == '0) begin
            count_nxt = cfg.d;
            state_nxt = SEL_DONE;
          end else begin
            state_nxt = SEL_SUM;
          end
        end
      end
      SEL_SUM: begin
        total_nxt = total_r + pcap_pkg::TOTAL_W'(ev_rd);
        cnt_nxt   = cnt_inc;
        if (cnt_inc >= d_r) begin
          state_nxt = SEL_MUL_LO;
        end
      end
      SEL_MUL_LO: begin
        prod_nxt  = mul_a * frac_r;
        state_nxt = SEL_MUL_HI;
      end
      SEL_MUL_HI: begin
        target_nxt = pcap_pkg::TARGET_W'(prod_r);
        prod_nxt   = mul_a * frac_r;
        state_nxt  = SEL_ADD;
      end
      SEL_ADD: begin
        target_nxt = target_r + (pcap_pkg::TARGET_W'(prod_r) << pcap_pkg::HALF_W);
        kept_nxt   = '0;
        cnt_nxt    = '0;
        state_nxt  = SEL_SCAN;
      end
      SEL_SCAN: begin
        if (scan_go) begin
          kept_nxt = kept_r + pcap_pkg::TOTAL_W'(ev_rd);
          cnt_nxt  = cnt_inc;
        end else begin
          count_nxt = (cnt_r == '0) ? pcap_pkg::POS_W'(1) : cnt_r;
          state_nxt = SEL_DONE;
        end
      end
      default: state_nxt = SEL_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ev_wr.we) begin
      ev_r[ev_wr.idx] <= ev_wr.value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SEL_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    d_r      <= d_nxt;
    cnt_r    <= cnt_nxt;
    count_r  <= count_nxt;
    frac_r   <= frac_nxt;
    total_r  <= total_nxt;
    kept_r   <= kept_nxt;
    target_r <= target_nxt;
    prod_r   <= prod_nxt;
  end

  assign res.done  = (state_r == SEL_DONE);
  assign res.count = count_r;

endmodule

>>> design/pca_eigen_projection_core.sv
// PCA projection core: row of MAC cells, one per output component, shifted out at frame end.
// Throughput: one item per cycle while a frame is filling; each sample updates all cells.
// After the last sample the core passes FLUSH and WAIT, where it holds until the count selector
// is done, and then in DRAIN registers one component per cycle as taken.
// Input is held off from the last sample of a frame until its last component is registered.
// Reset (synchronous, rst_n low): accumulators, frame position, registers to defaults.
`timescale 1ns / 1ps

module pca_eigen_projection_core (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  pcap_pkg::in_item_t                 in_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output pcap_pkg::out_item_t                out_data,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [pcap_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pcap_pkg::FRAC_W-1:0]        cfg_data
);

  typedef enum logic [1:0] {
    ST_RUN,
    ST_FLUSH,
    ST_WAIT,
    ST_DRAIN
  } core_state_t;

  core_state_t state_r, state_nxt;

  logic [pcap_pkg::POS_W-1:0]  input_dim_r;
  logic [pcap_pkg::POS_W-1:0]  output_count_r;
  logic                        select_var_r;
  logic [pcap_pkg::FRAC_W-1:0] keep_frac_r;

  logic [pcap_pkg::POS_W-1:0]  pos_r, pos_nxt;
  logic [pcap_pkg::POS_W-1:0]  n_r, n_nxt;
  logic [pcap_pkg::IDX_W-1:0]  emit_r, emit_nxt;
  logic                        out_valid_r, out_valid_nxt;
  pcap_pkg::out_item_t         out_data_r, out_data_nxt;

  logic [pcap_pkg::POS_W-1:0]  d;
  logic [pcap_pkg::POS_W:0]    pos_inc;
  logic                        at_end;
  logic [pcap_pkg::POS_W-1:0]  pos_eff;
  logic                        in_fire;
  logic                        sample_fire;
  logic                        cnt_start;
  logic                        slot_free;
  logic                        load_out;
  logic                        last_emit;

  pcap_pkg::cell_ctl_t         cell_ctl;
  pcap_pkg::sel_cfg_t          sel_cfg;
  pcap_pkg::ev_wr_t            ev_wr;
  pcap_pkg::cnt_res_t          cnt_res;
  logic [pcap_pkg::MAX_DIM-1:0] coef_we;
  logic [pcap_pkg::ACC_W-1:0]  acc_link [pcap_pkg::MAX_DIM+1];

  assign cfg_ready = rst_n;
  assign in_ready  = rst_n && (state_r == ST_RUN);
  assign in_fire   = in_valid && in_ready;
  assign sample_fire = in_fire && (in_data.opcode == pcap_pkg::OP_SAMPLE);

  assign d = (input_dim_r == '0) ? pcap_pkg::POS_W'(1) :
             (input_dim_r > pcap_pkg::POS_W'(pcap_pkg::MAX_DIM)) ?
             pcap_pkg::POS_W'(pcap_pkg::MAX_DIM) : input_dim_r;

  assign pos_inc   = {1'b0, pos_r} + 1'b1;
  assign at_end    = (pos_inc >= {1'b0, d});
  assign pos_eff   = at_end ? (d - 1'b1) : pos_r;
  assign cnt_start = sample_fire && at_end;

  assign slot_free = !out_valid_r || out_ready;
  assign load_out  = (state_r == ST_DRAIN) && slot_free;
  assign last_emit = (pcap_pkg::POS_W'({1'b0, emit_r}) + 1'b1) == n_r;

  assign cell_ctl.mac_en     = sample_fire;
  assign cell_ctl.pos        = pos_eff[pcap_pkg::IDX_W-1:0];
  assign cell_ctl.sample     = in_data.sample_value;
  assign cell_ctl.coef_row   = in_data.row_index;
  assign cell_ctl.coef_value = in_data.coef_value;
  assign cell_ctl.shift      = load_out;
  assign cell_ctl.clear      = load_out && last_emit;

  assign sel_cfg.d                  = d;
  assign sel_cfg.output_count       = output_count_r;
  assign sel_cfg.select_by_variance = select_var_r;
  assign sel_cfg.keep_fraction      = keep_frac_r;

  assign ev_wr.we    = in_fire && (in_data.opcode == pcap_pkg::OP_EIGEN);
  assign ev_wr.idx   = in_data.row_index;
  assign ev_wr.value = in_data.eigen_value;

  assign acc_link[pcap_pkg::MAX_DIM] = '0;

  for (genvar i = 0; i < pcap_pkg::MAX_DIM; i++) begin : g_cell
    assign coef_we[i] = in_fire && (in_data.opcode == pcap_pkg::OP_COEF) &&
                        (in_data.column_index == pcap_pkg::IDX_W'(i));
    pcap_mac_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl     (cell_ctl),
      .coef_we (coef_we[i]),
      .acc_in  (acc_link[i+1]),
      .acc_out (acc_link[i])
    );
  end

  pcap_count_sel u_count_sel (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (sel_cfg),
    .ev_wr (ev_wr),
    .start (cnt_start),
    .res   (cnt_res)
  );

  always_comb begin
    state_nxt     = state_r;
    pos_nxt       = pos_r;
    n_nxt         = n_r;
    emit_nxt      = emit_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    case (state_r)
      ST_RUN: begin
        if (sample_fire) begin
          if (at_end) begin
            pos_nxt   = '0;
            state_nxt = ST_FLUSH;
          end else begin
            pos_nxt = pos_inc[pcap_pkg::POS_W-1:0];
          end
        end
      end
      ST_FLUSH: state_nxt = ST_WAIT;
      ST_WAIT: begin
        if (cnt_res.done) begin
          n_nxt     = cnt_res.count;
          emit_nxt  = '0;
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (load_out) begin
          if (last_emit) begin
            state_nxt = ST_RUN;
          end else begin
            emit_nxt = emit_r + 1'b1;
          end
        end
      end
      default: state_nxt = ST_RUN;
    endcase
    if (load_out) begin
      out_valid_nxt                = 1'b1;
      out_data_nxt.component_index = emit_r;
      out_data_nxt.component_value = $signed(acc_link[0]);
      out_data_nxt.last_component  = last_emit;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_RUN;
      pos_r          <= '0;
      out_valid_r    <= 1'b0;
      input_dim_r    <= pcap_pkg::POS_W'(16);
      output_count_r <= pcap_pkg::POS_W'(16);
      select_var_r   <= 1'b0;
      keep_frac_r    <= pcap_pkg::FRAC_ONE;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          pcap_pkg::CFG_INPUT_DIM:    input_dim_r    <= cfg_data[pcap_pkg::POS_W-1:0];
          pcap_pkg::CFG_OUTPUT_COUNT: output_count_r <= cfg_data[pcap_pkg::POS_W-1:0];
          pcap_pkg::CFG_SELECT_VAR:   select_var_r   <= cfg_data[0];
          pcap_pkg::CFG_KEEP_FRAC:    keep_frac_r    <= cfg_data;
          default: ;
        endcase
      end
    end
    n_r        <= n_nxt;
    emit_r     <= emit_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef NO_ASSERTIONS
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WAIT && cnt_res.done) |-> (cnt_res.count != '0 && cnt_res.count <= d))
    else $error("component count outside 1..frame length");

  a_frame_closed: assert property (@(posedge clk) disable iff (!rst_n)
    (load_out && last_emit) |=> (state_r == ST_RUN && pos_r == '0))
    else $error("frame not closed after last component");

  a_pos_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_RUN) |-> (pos_r == '0))
    else $error("frame position not cleared during drain");
`endif

endmodule

>>> dv/pca_eigen_projection_core_test.sv
// Self-checking testbench for the PCA projection core: directed table, then random phases.
`timescale 1ns / 1ps

module pca_eigen_projection_core_test;
  import pcap_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int unsigned SETTLE_CYCLES = 2 * MAX_DIM + 16;
  localparam int unsigned SINK_HOLD_CYCLES = 300;
  localparam int unsigned CYCLE_LIMIT = 2000000;
  localparam int unsigned PHASE_ITEMS = 28;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t             kind;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [FRAC_W-1:0]     reg_val;
    in_item_t              item;
    logic                  typed;
    out_item_t             want;
  } step_row_t;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;
  logic      cfg_valid;
  logic      cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [FRAC_W-1:0]    cfg_data;

  logic signed [COEF_W-1:0] coef_shadow [MAX_DIM][MAX_DIM];
  logic [EIGEN_W-1:0]       eig_shadow [MAX_DIM];
  logic [ACC_W-1:0]         acc_shadow [MAX_DIM];
  int unsigned              frame_pos;
  logic [4:0]               dim_reg;
  logic [4:0]               count_reg;
  logic                     var_sel_reg;
  logic [FRAC_W-1:0]        keep_reg;

  out_item_t pending_components [$];
  out_item_t fresh_components [$];
  step_row_t directed_rows [$];

  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  bit src_fast = 1'b0;
  bit sink_fast = 1'b0;
  bit sink_hold = 1'b0;

  pca_eigen_projection_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("== FAIL ==");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    error_count++;
    $display("[%0t] %s", $time, msg);
  endtask

  function automatic int unsigned frame_length();
    if (dim_reg == 0) return 1;
    if (dim_reg > MAX_DIM) return MAX_DIM;
    return 32'(dim_reg);
  endfunction

  function automatic int unsigned component_count(input int unsigned d);
    longint unsigned total, kept, target, frac;
    int unsigned n, i;
    if (!var_sel_reg) begin
      n = 32'(count_reg);
      if (n < 1) n = 1;
      if (n > d) n = d;
      return n;
    end
    frac = 64'(keep_reg);
    if (frac == 0) return d;
    if (frac > 65536) frac = 65536;
    total = 0;
    for (i = 0; i < d; i++) total += 64'(eig_shadow[i]);
    target = total * frac;
    kept = 0;
    n = 0;
    while (n < d && (kept << 16) < target) begin
      kept += 64'(eig_shadow[n]);
      n++;
    end
    if (n < 1) n = 1;
    return n;
  endfunction

  task automatic project_item(input in_item_t it);
    int unsigned d, n, p, c;
    longint signed prod;
    out_item_t r;
    fresh_components.delete();
    case (it.opcode)
      OP_COEF: coef_shadow[it.row_index][it.column_index] = it.coef_value;
      OP_EIGEN: eig_shadow[it.row_index] = it.eigen_value;
      OP_SAMPLE: begin
        d = frame_length();
        p = (frame_pos >= d) ? d - 1 : frame_pos;
        for (c = 0; c < MAX_DIM; c++) begin
          prod = longint'(coef_shadow[p][c]) * longint'($signed(it.sample_value));
          acc_shadow[c] = acc_shadow[c] + prod[ACC_W-1:0];
        end
        if (p + 1 < d) begin
          frame_pos = p + 1;
        end else begin
          n = component_count(d);
          for (c = 0; c < n; c++) begin
            r.component_index = c[3:0];
            r.component_value = acc_shadow[c];
            r.last_component = (c + 1 == n);
            fresh_components.push_back(r);
          end
          for (c = 0; c < MAX_DIM; c++) acc_shadow[c] = '0;
          frame_pos = 0;
        end
      end
      default: ;
    endcase
  endtask

  function automatic in_item_t rand_item();
    in_item_t it;
    it.opcode = 2'($urandom_range(0, 3));
    it.row_index = 4'($urandom_range(0, 15));
    it.column_index = 4'($urandom_range(0, 15));
    it.coef_value = 16'($urandom);
    it.eigen_value = $urandom;
    it.sample_value = 16'($urandom);
    return it;
  endfunction

  function automatic in_item_t coef_item(input int unsigned r, input int unsigned c,
                                         input logic [15:0] v);
    in_item_t it;
    it = rand_item();
    it.opcode = OP_COEF;
    it.row_index = r[3:0];
    it.column_index = c[3:0];
    it.coef_value = v;
    return it;
  endfunction

  function automatic in_item_t eig_item(input int unsigned i, input logic [31:0] v);
    in_item_t it;
    it = rand_item();
    it.opcode = OP_EIGEN;
    it.row_index = i[3:0];
    it.eigen_value = v;
    return it;
  endfunction

  function automatic in_item_t sample_item(input logic [15:0] v);
    in_item_t it;
    it = rand_item();
    it.opcode = OP_SAMPLE;
    it.sample_value = v;
    return it;
  endfunction

  function automatic step_row_t row_item(input in_item_t it);
    step_row_t r;
    r = '0;
    r.kind = ROW_ITEM;
    r.item = it;
    return r;
  endfunction

  function automatic step_row_t row_cfg(input logic [CFG_IDX_W-1:0] idx,
                                        input logic [FRAC_W-1:0] val);
    step_row_t r;
    r = '0;
    r.kind = ROW_CFG;
    r.reg_idx = idx;
    r.reg_val = val;
    return r;
  endfunction

  function automatic step_row_t row_single(input logic [15:0] v, input longint value);
    step_row_t r;
    r = row_item(sample_item(v));
    r.typed = 1'b1;
    r.want.component_index = 4'd0;
    r.want.component_value = value[ACC_W-1:0];
    r.want.last_component = 1'b1;
    return r;
  endfunction

  task automatic push_item(input in_item_t it, input bit typed, input out_item_t want);
    int unsigned gap, k;
    gap = src_fast ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    project_item(it);
    if (typed) begin
      pending_components.push_back(want);
    end else begin
      for (k = 0; k < fresh_components.size(); k++)
        pending_components.push_back(fresh_components[k]);
    end
    @(negedge clk);
  endtask

  task automatic settle_idle(input int unsigned extra);
    in_valid <= 1'b0;
    while (pending_components.size() != 0) @(negedge clk);
    repeat (extra) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [FRAC_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_INPUT_DIM:    dim_reg = val[4:0];
      CFG_OUTPUT_COUNT: count_reg = val[4:0];
      CFG_SELECT_VAR:   var_sel_reg = val[0];
      CFG_KEEP_FRAC:    keep_reg = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_phase_config(input int unsigned ph);
    int unsigned dim, cnt, sel, keep, pick;
    case (ph)
      0: begin dim = 16; cnt = 16; sel = 0; keep = 65536; end
      1: begin dim = 1;  cnt = 0;  sel = 0; keep = 0; end
      2: begin dim = 31; cnt = 31; sel = 1; keep = 131071; end
      3: begin dim = 0;  cnt = 1;  sel = 1; keep = 1; end
      default: begin
        dim = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 5) : $urandom_range(0, 31);
        cnt = $urandom_range(0, 31);
        sel = $urandom_range(0, 1);
        pick = $urandom_range(0, 3);
        case (pick)
          0: keep = 0;
          1: keep = 65536;
          2: keep = $urandom_range(65537, 131071);
          default: keep = $urandom_range(1, 65535);
        endcase
      end
    endcase
    settle_idle(SETTLE_CYCLES);
    write_reg(CFG_INPUT_DIM, FRAC_W'(($urandom << 5) | dim));
    write_reg(CFG_OUTPUT_COUNT, FRAC_W'(($urandom << 5) | cnt));
    write_reg(CFG_SELECT_VAR, FRAC_W'(($urandom << 1) | sel));
    write_reg(CFG_KEEP_FRAC, FRAC_W'(keep));
  endtask

  task automatic run_phase(input int unsigned quota, input bit pause_midway);
    int unsigned done_cnt, pick;
    bit paused;
    in_item_t it;
    done_cnt = 0;
    paused = 1'b0;
    while (done_cnt < quota) begin
      it = rand_item();
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
        it.opcode = OP_COEF;
      end else if (pick < 22) begin
        it.opcode = OP_EIGEN;
        if (pick < 16) it.eigen_value = $urandom_range(0, 255);
      end else if (pick < 26) begin
        it.opcode = OP_UNUSED;
      end else begin
        it.opcode = OP_SAMPLE;
        if (pick >= 94) it.sample_value = pick[0] ? 16'sh7FFF : 16'sh8000;
      end
      push_item(it, 1'b0, '0);
      if (it.opcode != OP_UNUSED) done_cnt++;
      if (pause_midway && !paused && done_cnt >= quota / 2) begin
        settle_idle(1);
        paused = 1'b1;
      end
    end
  endtask

  initial begin : result_taker
    int unsigned stall;
    out_ready = 1'b0;
    @(negedge clk);
    forever begin
      if (sink_hold) begin
        stall = SINK_HOLD_CYCLES;
        sink_hold = 1'b0;
      end else begin
        stall = sink_fast ? 0 : $urandom_range(0, 19);
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && rst_n));
      @(negedge clk);
    end
  end

  always @(posedge clk) begin : check_results
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_components.size() == 0) begin
        report_mismatch($sformatf("unexpected component %0d value %0d last %0b",
                                  out_data.component_index, out_data.component_value,
                                  out_data.last_component));
      end else begin
        want = pending_components.pop_front();
        if (out_data.component_index !== want.component_index)
          report_mismatch($sformatf("component_index got %0d want %0d",
                                    out_data.component_index, want.component_index));
        if (out_data.component_value !== want.component_value)
          report_mismatch($sformatf("component %0d value got %0d want %0d",
                                    want.component_index, out_data.component_value,
                                    want.component_value));
        if (out_data.last_component !== want.last_component)
          report_mismatch($sformatf("component %0d last got %0b want %0b",
                                    want.component_index, out_data.last_component,
                                    want.last_component));
      end
    end
  end

  initial begin : main_seq
    int unsigned r, c, i, ph;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    dim_reg = 5'd16;
    count_reg = 5'd16;
    var_sel_reg = 1'b0;
    keep_reg = FRAC_ONE;
    frame_pos = 0;
    for (c = 0; c < MAX_DIM; c++) acc_shadow[c] = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // fill both stores before any sample reads them
    for (r = 0; r < MAX_DIM; r++)
      for (c = 0; c < MAX_DIM; c++)
        push_item(coef_item(r, c, 16'($urandom)), 1'b0, '0);
    for (i = 0; i < MAX_DIM; i++)
      push_item(eig_item(i, $urandom), 1'b0, '0);

    directed_rows.push_back(row_cfg(CFG_INPUT_DIM, 17'd1));
    directed_rows.push_back(row_cfg(CFG_OUTPUT_COUNT, 17'd1));
    directed_rows.push_back(row_item(coef_item(0, 0, 16'h8000)));
    directed_rows.push_back(row_single(16'h8000, 64'sd1073741824));
    directed_rows.push_back(row_single(16'h7FFF, -64'sd1073709056));
    directed_rows.push_back(row_item(coef_item(0, 0, 16'h7FFF)));
    directed_rows.push_back(row_single(16'h7FFF, 64'sd1073676289));
    directed_rows.push_back(row_item('{OP_UNUSED, 4'hF, 4'hF, 16'h8000, 32'hFFFF_FFFF,
                                       16'h7FFF}));
    directed_rows.push_back(row_single(16'h8000, -64'sd1073709056));
    directed_rows.push_back(row_cfg(CFG_INPUT_DIM, 17'd0));
    directed_rows.push_back(row_cfg(CFG_OUTPUT_COUNT, 17'd0));
    directed_rows.push_back(row_single(16'h0001, 64'sd32767));
    directed_rows.push_back(row_cfg(CFG_INPUT_DIM, 17'd2));
    directed_rows.push_back(row_cfg(CFG_OUTPUT_COUNT, 17'd5));
    directed_rows.push_back(row_item(sample_item(16'($urandom))));
    directed_rows.push_back(row_item(sample_item(16'($urandom))));
    directed_rows.push_back(row_cfg(CFG_INPUT_DIM, 17'd3));
    directed_rows.push_back(row_item(sample_item(16'($urandom))));
    directed_rows.push_back(row_cfg(CFG_INPUT_DIM, 17'd1));
    directed_rows.push_back(row_item(sample_item(16'($urandom))));
    directed_rows.push_back(row_cfg(CFG_INPUT_DIM, 17'd2));
    directed_rows.push_back(row_cfg(CFG_SELECT_VAR, 17'd1));
    directed_rows.push_back(row_cfg(CFG_KEEP_FRAC, 17'd0));
    directed_rows.push_back(row_item(eig_item(0, 32'hFFFF_FFFF)));
    directed_rows.push_back(row_item(eig_item(1, 32'h0000_0000)));
    directed_rows.push_back(row_item(sample_item(16'h7FFF)));
    directed_rows.push_back(row_item(sample_item(16'h8000)));
    directed_rows.push_back(row_cfg(CFG_KEEP_FRAC, 17'h1FFFF));
    directed_rows.push_back(row_item(sample_item(16'($urandom))));
    directed_rows.push_back(row_item(sample_item(16'($urandom))));
    directed_rows.push_back(row_item(eig_item(0, 32'h0000_0000)));
    directed_rows.push_back(row_cfg(CFG_KEEP_FRAC, 17'd1));
    directed_rows.push_back(row_item(sample_item(16'($urandom))));
    directed_rows.push_back(row_item(sample_item(16'($urandom))));

    for (i = 0; i < directed_rows.size(); i++) begin
      if (directed_rows[i].kind == ROW_CFG) begin
        settle_idle(SETTLE_CYCLES);
        write_reg(directed_rows[i].reg_idx, directed_rows[i].reg_val);
      end else begin
        push_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);
      end
    end

    for (ph = 0; ph < 9; ph++) begin
      set_phase_config(ph);
      src_fast = ($urandom_range(0, 3) == 0);
      sink_fast = ($urandom_range(0, 3) == 0);
      if (ph == 4) begin
        // stall the result side while input keeps coming
        src_fast = 1'b1;
        sink_fast = 1'b0;
        sink_hold = 1'b1;
      end
      run_phase(PHASE_ITEMS, ph == 6);
    end

    settle_idle(SETTLE_CYCLES);
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

>>> pca_eigen_projection_core.f
design/pcap_pkg.sv
design/pcap_mac_cell.sv
design/pcap_count_sel.sv
design/pca_eigen_projection_core.sv
dv/pca_eigen_projection_core_test.sv
